@@ rtl/core/nc2d_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nc2d_pkg
// Shared types, opcodes and lookup functions for the 2D narrow-phase unit.
// ----------------------------------------------------------------------------
package nc2d_pkg;

  localparam int POS_W      = 32;
  localparam int SIZE_W     = 31;
  localparam int NRM_W      = 16;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 15;

  typedef enum logic [2:0] {
    OP_CC = 3'd0,
    OP_CB = 3'd1,
    OP_CP = 3'd2,
    OP_BB = 3'd3,
    OP_BP = 3'd4
  } op_t;

  localparam logic signed [NRM_W-1:0] Q14_ONE  = 16'sd16384;
  localparam logic signed [NRM_W-1:0] Q14_MONE = -16'sd16384;

  // Values carried alongside the square-root and divider chains
  typedef struct packed {
    logic                     use_len;
    logic                     op_ok;
    logic                     sgn_x;
    logic                     sgn_y;
    logic                     shift;
    logic signed [34:0]       addend;
    logic signed [39:0]       early_depth;
    logic signed [NRM_W-1:0]  early_nx;
    logic signed [NRM_W-1:0]  early_ny;
    logic [SIZE_W-1:0]        ux;
    logic [SIZE_W-1:0]        uy;
  } carry_t;

  // Axis normals for circle inside box: right, left, top, bottom edge
  function automatic logic signed [2*NRM_W-1:0] cb_normal(input logic [1:0] k);
    logic signed [2*NRM_W-1:0] r;
    case (k)
      2'd0:    r = {Q14_MONE, 16'sd0};
      2'd1:    r = {Q14_ONE, 16'sd0};
      2'd2:    r = {16'sd0, Q14_MONE};
      default: r = {16'sd0, Q14_ONE};
    endcase
    return r;
  endfunction

  // Axis normals for box-box overlap selection
  function automatic logic signed [2*NRM_W-1:0] bb_normal(input logic [1:0] k);
    logic signed [2*NRM_W-1:0] r;
    case (k)
      2'd0:    r = {Q14_ONE, 16'sd0};
      2'd1:    r = {Q14_MONE, 16'sd0};
      2'd2:    r = {16'sd0, Q14_ONE};
      default: r = {16'sd0, Q14_MONE};
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/narrowphase_collision_2d_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// narrowphase_collision_2d_unit
// Pipelined 2D narrow-phase test: depth, contact normal and touching flag.
// ----------------------------------------------------------------------------
// One shape pair is taken every cycle while out_stall does not hold a result.
// The pipeline is four set-up stages (differences and plane products, clamp
// and magnitudes, squares and overlap compare, sum of squares), a 32-stage
// square root that yields one root bit per stage, a 15-stage divider that
// yields one normal bit per stage for both axes, and the output register.
// While out_stall holds a result, the whole pipeline holds with it.
module narrowphase_collision_2d_unit
  import nc2d_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               opcode,
  input  wire logic signed [POS_W-1:0]  a_pos_x,
  input  wire logic signed [POS_W-1:0]  a_pos_y,
  input  wire logic [SIZE_W-1:0]        a_size_x,
  input  wire logic [SIZE_W-1:0]        a_size_y,
  input  wire logic signed [POS_W-1:0]  b_pos_x,
  input  wire logic signed [POS_W-1:0]  b_pos_y,
  input  wire logic [SIZE_W-1:0]        b_size_x,
  input  wire logic [SIZE_W-1:0]        b_size_y,
  input  wire logic signed [NRM_W-1:0]  plane_normal_x,
  input  wire logic signed [NRM_W-1:0]  plane_normal_y,
  input  wire logic signed [POS_W-1:0]  plane_offset,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed [POS_W-1:0]       depth,
  output logic signed [NRM_W-1:0]       normal_x,
  output logic signed [NRM_W-1:0]       normal_y,
  output logic                          touching
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1: differences and plane products ----------------
  logic signed [34:0] ax_e, ay_e, bx_e, by_e, ahx_e, ahy_e, bhx_e, bhy_e;
  assign ax_e  = {{3{a_pos_x[31]}}, a_pos_x};
  assign ay_e  = {{3{a_pos_y[31]}}, a_pos_y};
  assign bx_e  = {{3{b_pos_x[31]}}, b_pos_x};
  assign by_e  = {{3{b_pos_y[31]}}, b_pos_y};
  assign ahx_e = {4'b0, a_size_x};
  assign ahy_e = {4'b0, a_size_y};
  assign bhx_e = {4'b0, b_size_x};
  assign bhy_e = {4'b0, b_size_y};

  logic                    s1_vld;
  logic [2:0]              s1_op;
  logic signed [34:0]      s1_hx, s1_lx, s1_hy, s1_ly, s1_cx, s1_cy;
  logic signed [34:0]      s1_bb0, s1_bb1, s1_bb2, s1_bb3;
  logic signed [47:0]      s1_p1, s1_p2, s1_p3, s1_p4;
  logic signed [POS_W-1:0] s1_off;
  logic [SIZE_W-1:0]       s1_ahx, s1_bhx;
  logic signed [NRM_W-1:0] s1_nnx, s1_nny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op  <= opcode;
      s1_hx  <= bx_e + bhx_e - ax_e;
      s1_lx  <= bx_e - bhx_e - ax_e;
      s1_hy  <= by_e + bhy_e - ay_e;
      s1_ly  <= by_e - bhy_e - ay_e;
      s1_cx  <= bx_e - ax_e;
      s1_cy  <= by_e - ay_e;
      s1_bb0 <= ax_e + ahx_e - bx_e + bhx_e;
      s1_bb1 <= bx_e + bhx_e - ax_e + ahx_e;
      s1_bb2 <= ay_e + ahy_e - by_e + bhy_e;
      s1_bb3 <= by_e + bhy_e - ay_e + ahy_e;
      s1_p1  <= a_pos_x * plane_normal_x;
      s1_p2  <= $signed({1'b0, a_size_x}) * plane_normal_x;
      s1_p3  <= a_pos_y * plane_normal_y;
      s1_p4  <= $signed({1'b0, a_size_y}) * plane_normal_y;
      s1_off <= plane_offset;
      s1_ahx <= a_size_x;
      s1_bhx <= b_size_x;
      s1_nnx <= (plane_normal_x == 16'sh8000) ? 16'sh7fff : -plane_normal_x;
      s1_nny <= (plane_normal_y == 16'sh8000) ? 16'sh7fff : -plane_normal_y;
    end
  end

  // ---------------- stage 2: clamp, magnitudes, plane sums ----------------
  logic signed [34:0] d2x, d2y, m2x, m2y;
  logic signed [34:0] v2_0, v2_1, v2_2, v2_3, add2;
  logic signed [49:0] p1e, p2e, p3e, p4e, ap2, ap4, t2;
  logic               inside2;

  always_comb begin
    d2x = '0;
    d2y = '0;
    case (s1_op)
      OP_CC: begin
        d2x = s1_cx;
        d2y = s1_cy;
      end
      OP_CB: begin
        d2x = (s1_lx > 0) ? s1_lx : ((s1_hx < 0) ? s1_hx : 35'sd0);
        d2y = (s1_ly > 0) ? s1_ly : ((s1_hy < 0) ? s1_hy : 35'sd0);
      end
      default: begin
        d2x = '0;
        d2y = '0;
      end
    endcase
    m2x = (d2x < 0) ? -d2x : d2x;
    m2y = (d2y < 0) ? -d2y : d2y;
    inside2 = (s1_lx <= 0) && (s1_hx >= 0) && (s1_ly <= 0) && (s1_hy >= 0);

    if (s1_op == OP_CB) begin
      v2_0 = (s1_hx < 0) ? -s1_hx : s1_hx;
      v2_1 = (s1_lx < 0) ? -s1_lx : s1_lx;
      v2_2 = (s1_hy < 0) ? -s1_hy : s1_hy;
      v2_3 = (s1_ly < 0) ? -s1_ly : s1_ly;
    end else begin
      v2_0 = s1_bb0;
      v2_1 = s1_bb1;
      v2_2 = s1_bb2;
      v2_3 = s1_bb3;
    end
    add2 = (s1_op == OP_CC) ? 35'($signed({4'b0, s1_ahx}) + $signed({4'b0, s1_bhx}))
                            : $signed({4'b0, s1_ahx});

    p1e = 50'(s1_p1);
    p2e = 50'(s1_p2);
    p3e = 50'(s1_p3);
    p4e = 50'(s1_p4);
    ap2 = (p2e < 0) ? -p2e : p2e;
    ap4 = (p4e < 0) ? -p4e : p4e;
    // Box-plane: the deepest corner is the one with the smallest dot product
    if (s1_op == OP_BP) begin
      t2 = p1e + p3e - ap2 - ap4 + 50'sd8192;
    end else begin
      t2 = p1e + p3e + 50'sd8192;
    end
  end

  logic                    s2_vld;
  logic [2:0]              s2_op;
  logic [31:0]             s2_mx, s2_my;
  logic                    s2_sx, s2_sy, s2_inside;
  logic signed [34:0]      s2_v0, s2_v1, s2_v2, s2_v3, s2_add;
  logic signed [49:0]      s2_t;
  logic signed [POS_W-1:0] s2_off;
  logic [SIZE_W-1:0]       s2_ahx;
  logic signed [NRM_W-1:0] s2_nnx, s2_nny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op     <= s1_op;
      s2_mx     <= m2x[31:0];
      s2_my     <= m2y[31:0];
      s2_sx     <= d2x[34];
      s2_sy     <= d2y[34];
      s2_inside <= inside2;
      s2_v0     <= v2_0;
      s2_v1     <= v2_1;
      s2_v2     <= v2_2;
      s2_v3     <= v2_3;
      s2_add    <= add2;
      s2_t      <= t2;
      s2_off    <= s1_off;
      s2_ahx    <= s1_ahx;
      s2_nnx    <= s1_nnx;
      s2_nny    <= s1_nny;
    end
  end

  // ---------------- stage 3: squares, first compare, plane depth ----------------
  logic              shift3;
  logic [SIZE_W-1:0] ux3, uy3;
  logic signed [49:0] pd3;

  always_comb begin
    shift3 = s2_mx[31] | s2_my[31];
    ux3    = shift3 ? s2_mx[31:1] : s2_mx[30:0];
    uy3    = shift3 ? s2_my[31:1] : s2_my[30:0];
    pd3    = 50'(s2_off) - (s2_t >>> 14);
    if (s2_op == OP_CP) begin
      pd3 = pd3 + $signed({19'b0, s2_ahx});
    end
  end

  logic                    s3_vld;
  logic [2:0]              s3_op;
  logic [SIZE_W-1:0]       s3_ux, s3_uy;
  logic [61:0]             s3_sqx, s3_sqy;
  logic                    s3_shift, s3_sx, s3_sy, s3_inside;
  logic signed [34:0]      s3_ma, s3_mb, s3_add;
  logic [1:0]              s3_ka, s3_kb;
  logic signed [39:0]      s3_pd;
  logic [SIZE_W-1:0]       s3_ahx;
  logic signed [NRM_W-1:0] s3_nnx, s3_nny;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (en) begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op     <= s2_op;
      s3_ux     <= ux3;
      s3_uy     <= uy3;
      s3_sqx    <= 62'(ux3 * ux3);
      s3_sqy    <= 62'(uy3 * uy3);
      s3_shift  <= shift3;
      s3_sx     <= s2_sx;
      s3_sy     <= s2_sy;
      s3_inside <= s2_inside;
      // first index wins on ties
      s3_ma     <= (s2_v1 < s2_v0) ? s2_v1 : s2_v0;
      s3_ka     <= (s2_v1 < s2_v0) ? 2'd1 : 2'd0;
      s3_mb     <= (s2_v3 < s2_v2) ? s2_v3 : s2_v2;
      s3_kb     <= (s2_v3 < s2_v2) ? 2'd3 : 2'd2;
      s3_add    <= s2_add;
      s3_pd     <= pd3[39:0];
      s3_ahx    <= s2_ahx;
      s3_nnx    <= s2_nnx;
      s3_nny    <= s2_nny;
    end
  end

  // ---------------- stage 4: sum of squares, early results ----------------
  logic signed [34:0]      vmin4;
  logic [1:0]              kmin4;
  logic signed [2*NRM_W-1:0] nrm4;
  carry_t                  c4;

  always_comb begin
    vmin4 = (s3_mb < s3_ma) ? s3_mb : s3_ma;
    kmin4 = (s3_mb < s3_ma) ? s3_kb : s3_ka;
    c4 = '0;
    c4.sgn_x  = s3_sx;
    c4.sgn_y  = s3_sy;
    c4.shift  = s3_shift;
    c4.addend = s3_add;
    c4.ux     = s3_ux;
    c4.uy     = s3_uy;
    c4.op_ok  = 1'b1;
    c4.early_depth = -40'sd2147483648;
    nrm4 = '0;
    case (s3_op)
      OP_CC: begin
        c4.use_len = 1'b1;
      end
      OP_CB: begin
        c4.use_len     = !s3_inside;
        nrm4           = cb_normal(kmin4);
        c4.early_depth = 40'(vmin4) + $signed({9'b0, s3_ahx});
        c4.early_nx    = nrm4[2*NRM_W-1:NRM_W];
        c4.early_ny    = nrm4[NRM_W-1:0];
      end
      OP_BB: begin
        nrm4           = bb_normal(kmin4);
        c4.early_depth = 40'(vmin4);
        c4.early_nx    = nrm4[2*NRM_W-1:NRM_W];
        c4.early_ny    = nrm4[NRM_W-1:0];
      end
      OP_CP, OP_BP: begin
        c4.early_depth = s3_pd;
        c4.early_nx    = s3_nnx;
        c4.early_ny    = s3_nny;
      end
      default: begin
        c4.op_ok = 1'b0;
      end
    endcase
  end

  logic        s4_vld;
  logic [63:0] s4_sum;
  carry_t      s4_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (en) begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_sum <= 64'(s3_sqx) + 64'(s3_sqy);
      s4_c   <= c4;
    end
  end

  // ---------------- square root: one root bit per stage ----------------
  logic        sq_vld [SQRT_STEPS];
  logic [63:0] sq_n   [SQRT_STEPS];
  logic [63:0] sq_r   [SQRT_STEPS];
  carry_t      sq_c   [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic        v_in;
    logic [63:0] n_in, r_in, trial;
    carry_t      c_in;

    if (k == 0) begin : g_first
      assign v_in = s4_vld;
      assign n_in = s4_sum;
      assign r_in = '0;
      assign c_in = s4_c;
    end else begin : g_next
      assign v_in = sq_vld[k-1];
      assign n_in = sq_n[k-1];
      assign r_in = sq_r[k-1];
      assign c_in = sq_c[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k] <= 1'b0;
      end else if (en) begin
        sq_vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_c[k] <= c_in;
        if (n_in >= trial) begin
          sq_n[k] <= n_in - trial;
          sq_r[k] <= (r_in >> 1) + BIT;
        end else begin
          sq_n[k] <= n_in;
          sq_r[k] <= r_in >> 1;
        end
      end
    end
  end

  // ---------------- divider: one normal bit per stage, both axes ----------------
  logic                 dv_vld [DIV_STEPS];
  logic [32:0]          dv_rx  [DIV_STEPS];
  logic [32:0]          dv_ry  [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_qx  [DIV_STEPS];
  logic [DIV_STEPS-1:0] dv_qy  [DIV_STEPS];
  logic [31:0]          dv_l0  [DIV_STEPS];
  carry_t               dv_c   [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic                 v_in;
    logic [32:0]          rx_in, ry_in, rx_s, ry_s, den;
    logic [DIV_STEPS-1:0] qx_in, qy_in;
    logic [31:0]          l0_in;
    carry_t               c_in;

    if (j == 0) begin : g_first
      assign v_in  = sq_vld[SQRT_STEPS-1];
      assign l0_in = sq_r[SQRT_STEPS-1][31:0];
      assign c_in  = sq_c[SQRT_STEPS-1];
      assign qx_in = '0;
      assign qy_in = '0;
      // the component never exceeds the length, so no shift on the first bit
      assign rx_s  = {2'b0, sq_c[SQRT_STEPS-1].ux};
      assign ry_s  = {2'b0, sq_c[SQRT_STEPS-1].uy};
      assign rx_in = rx_s;
      assign ry_in = ry_s;
    end else begin : g_next
      assign v_in  = dv_vld[j-1];
      assign l0_in = dv_l0[j-1];
      assign c_in  = dv_c[j-1];
      assign qx_in = dv_qx[j-1];
      assign qy_in = dv_qy[j-1];
      assign rx_in = dv_rx[j-1];
      assign ry_in = dv_ry[j-1];
      assign rx_s  = {rx_in[31:0], 1'b0};
      assign ry_s  = {ry_in[31:0], 1'b0};
    end

    assign den = {1'b0, l0_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j] <= 1'b0;
      end else if (en) begin
        dv_vld[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_l0[j] <= l0_in;
        dv_c[j]  <= c_in;
        dv_qx[j] <= {qx_in[DIV_STEPS-2:0], rx_s >= den};
        dv_qy[j] <= {qy_in[DIV_STEPS-2:0], ry_s >= den};
        dv_rx[j] <= (rx_s >= den) ? rx_s - den : rx_s;
        dv_ry[j] <= (ry_s >= den) ? ry_s - den : ry_s;
      end
    end
  end

  // ---------------- output stage ----------------
  carry_t                  cf;
  logic [31:0]             l0f;
  logic [DIV_STEPS-1:0]    qxf, qyf;
  logic signed [40:0]      len_f, dep_f;
  logic signed [NRM_W-1:0] nx_f, ny_f, qxs, qys;
  logic signed [POS_W-1:0] dep_sat;

  always_comb begin
    cf    = dv_c[DIV_STEPS-1];
    l0f   = dv_l0[DIV_STEPS-1];
    qxf   = dv_qx[DIV_STEPS-1];
    qyf   = dv_qy[DIV_STEPS-1];
    len_f = cf.shift ? $signed({8'b0, l0f, 1'b0}) : $signed({9'b0, l0f});
    qxs   = $signed({1'b0, qxf});
    qys   = $signed({1'b0, qyf});
    if (cf.use_len) begin
      dep_f = 41'(cf.addend) - len_f;
      if (l0f == '0) begin
        nx_f = '0;
        ny_f = '0;
      end else begin
        nx_f = cf.sgn_x ? -qxs : qxs;
        ny_f = cf.sgn_y ? -qys : qys;
      end
    end else begin
      dep_f = 41'(cf.early_depth);
      nx_f  = cf.early_nx;
      ny_f  = cf.early_ny;
    end
    if (dep_f > 41'sd2147483647) begin
      dep_sat = 32'sh7fffffff;
    end else if (dep_f < -41'sd2147483648) begin
      dep_sat = 32'sh80000000;
    end else begin
      dep_sat = dep_f[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_vld[DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth    <= dep_sat;
      normal_x <= nx_f;
      normal_y <= ny_f;
      touching <= cf.op_ok && !dep_f[40];
    end
  end

endmodule
`default_nettype wire

@@ sim/tb_narrowphase_collision_2d_unit.sv @@
// ----------------------------------------------------------------------------
// tb_narrowphase_collision_2d_unit
// Streams shape pairs into the narrow-phase unit and checks depth, normal and
// touching of every result against an in-bench integer predictor.
// ----------------------------------------------------------------------------
module tb_narrowphase_collision_2d_unit;
  import nc2d_pkg::*;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] ax, ay;
    logic [30:0]        ahx, ahy;
    logic signed [31:0] bx, by;
    logic [30:0]        bhx, bhy;
    logic signed [15:0] pnx, pny;
    logic signed [31:0] poff;
  } pair_t;

  typedef struct {
    logic signed [31:0] depth;
    logic signed [15:0] nx, ny;
    logic               touch;
  } contact_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] opcode = '0;
  logic signed [31:0] a_pos_x = '0, a_pos_y = '0, b_pos_x = '0, b_pos_y = '0;
  logic [30:0] a_size_x = '0, a_size_y = '0, b_size_x = '0, b_size_y = '0;
  logic signed [15:0] plane_normal_x = '0, plane_normal_y = '0;
  logic signed [31:0] plane_offset = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] depth;
  logic signed [15:0] normal_x, normal_y;
  logic touching;

  pair_t    pending_pairs[$];
  contact_t expected_contacts[$];
  int       error_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;

  always #10 clk = ~clk;

  narrowphase_collision_2d_unit uut (.*);

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // length in Q16.16, unit direction in Q2.14
  function automatic longint vec_length(longint dx, longint dy, output longint nx,
                                        output longint ny);
    longint unsigned mx, my, l0;
    int sh;
    mx = abs64(dx);
    my = abs64(dy);
    sh = (mx >= 64'h8000_0000 || my >= 64'h8000_0000) ? 1 : 0;
    mx >>= sh;
    my >>= sh;
    l0 = int_sqrt(mx * mx + my * my);
    if (l0 == 0) begin
      nx = 0;
      ny = 0;
      return 0;
    end
    nx = longint'((mx * 16384) / l0);
    ny = longint'((my * 16384) / l0);
    if (dx < 0) nx = -nx;
    if (dy < 0) ny = -ny;
    return longint'(l0 << sh);
  endfunction

  function automatic longint dot_q16(longint px, longint py, longint nx, longint ny);
    longint t;
    t = px * nx + py * ny + 8192;
    if (t >= 0) return t >>> 14;
    return -longint'((longint'(-t) + 16383) >> 14);
  endfunction

  function automatic longint negate_sat(longint v);
    return (-v > 32767) ? 32767 : -v;
  endfunction

  function automatic int min_index(longint v[4]);
    int k;
    k = 0;
    for (int i = 1; i < 4; i++) if (v[i] < v[k]) k = i;
    return k;
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    contact_t c;
    longint ax, ay, ahx, ahy, bx, by, bhx, bhy, pnx, pny, poff;
    longint d, nx, ny, cx, cy, px, py, t;
    longint v[4];
    int k;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    ahx = p.ahx; ahy = p.ahy; bhx = p.bhx; bhy = p.bhy;
    pnx = p.pnx; pny = p.pny; poff = p.poff;
    d = -64'sd2147483648;
    nx = 0;
    ny = 0;
    case (p.op)
      OP_CC: d = ahx + bhx - vec_length(bx - ax, by - ay, nx, ny);
      OP_CB: begin
        cx = ax;
        cy = ay;
        if (cx < bx - bhx) cx = bx - bhx;
        if (cx > bx + bhx) cx = bx + bhx;
        if (cy < by - bhy) cy = by - bhy;
        if (cy > by + bhy) cy = by + bhy;
        if (cx == ax && cy == ay) begin
          v[0] = abs64(bx + bhx - ax);
          v[1] = abs64(bx - bhx - ax);
          v[2] = abs64(by + bhy - ay);
          v[3] = abs64(by - bhy - ay);
          k = min_index(v);
          d = v[k] + ahx;
          nx = (k == 0) ? -16384 : (k == 1) ? 16384 : 0;
          ny = (k == 2) ? -16384 : (k == 3) ? 16384 : 0;
        end else begin
          d = ahx - vec_length(cx - ax, cy - ay, nx, ny);
        end
      end
      OP_CP: begin
        d = poff + ahx - dot_q16(ax, ay, pnx, pny);
        nx = negate_sat(pnx);
        ny = negate_sat(pny);
      end
      OP_BB: begin
        v[0] = (ax + ahx) - (bx - bhx);
        v[1] = (bx + bhx) - (ax - ahx);
        v[2] = (ay + ahy) - (by - bhy);
        v[3] = (by + bhy) - (ay - ahy);
        k = min_index(v);
        d = v[k];
        nx = (k == 0) ? 16384 : (k == 1) ? -16384 : 0;
        ny = (k == 2) ? 16384 : (k == 3) ? -16384 : 0;
      end
      OP_BP: begin
        for (int i = 0; i < 4; i++) begin
          px = i[0] ? ax + ahx : ax - ahx;
          py = i[1] ? ay + ahy : ay - ahy;
          t = poff - dot_q16(px, py, pnx, pny);
          if (i == 0 || t > d) d = t;
        end
        nx = negate_sat(pnx);
        ny = negate_sat(pny);
      end
      default: ;
    endcase
    if (d > 64'sd2147483647) d = 64'sd2147483647;
    if (d < -64'sd2147483648) d = -64'sd2147483648;
    c.depth = d[31:0];
    c.nx = nx[15:0];
    c.ny = ny[15:0];
    c.touch = (p.op <= OP_BP) && (d >= 0);
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // driver: hold payload while stalled, advance on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          pair_t p;
          p = pending_pairs.pop_front();
          expected_contacts.push_back(predict_contact(p));
          in_valid <= 1'b1;
          opcode <= p.op;
          a_pos_x <= p.ax; a_pos_y <= p.ay; a_size_x <= p.ahx; a_size_y <= p.ahy;
          b_pos_x <= p.bx; b_pos_y <= p.by; b_size_x <= p.bhx; b_size_y <= p.bhy;
          plane_normal_x <= p.pnx; plane_normal_y <= p.pny; plane_offset <= p.poff;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_contacts.size() == 0) begin
          report_mismatch("unexpected result depth", depth, 0);
        end else begin
          contact_t e;
          e = expected_contacts.pop_front();
          if (depth !== e.depth) report_mismatch("depth", depth, e.depth);
          if (normal_x !== e.nx) report_mismatch("normal_x", normal_x, e.nx);
          if (normal_y !== e.ny) report_mismatch("normal_y", normal_y, e.ny);
          if (touching !== e.touch) report_mismatch("touching", touching, e.touch);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic logic [31:0] rand_pos(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  function automatic logic [30:0] rand_size(int mode);
    case (mode)
      0: return 31'($urandom);
      1: return 31'($urandom_range(1000000));
      default: return 31'($urandom_range(65535));
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int m;
    int ang;
    m = $urandom_range(2);
    p.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
    p.ax = rand_pos(m); p.ay = rand_pos(m);
    p.bx = rand_pos(m); p.by = rand_pos(m);
    p.ahx = rand_size(m); p.ahy = rand_size(m);
    p.bhx = rand_size(m); p.bhy = rand_size(m);
    // put the circle centre inside the box now and then
    if (p.op == OP_CB && $urandom_range(2) == 0) begin
      p.ax = p.bx + 32'($signed($urandom_range(200)) - 100);
      p.ay = p.by + 32'($signed($urandom_range(200)) - 100);
      p.bhx = 31'($urandom_range(1000, 100));
      p.bhy = 31'($urandom_range(1000, 100));
    end
    if ($urandom_range(9) == 0) begin
      p.pnx = 16'($urandom);
      p.pny = 16'($urandom);
    end else begin
      ang = $urandom_range(16384);
      p.pnx = $urandom_range(1) ? 16'(ang) : -16'(ang);
      p.pny = $urandom_range(1) ? 16'(16384 - ang) : -16'(16384 - ang);
    end
    p.poff = rand_pos(m);
    return p;
  endfunction

  function automatic pair_t make_pair(logic [2:0] op, logic [31:0] ax, logic [31:0] ay,
      logic [30:0] ahx, logic [30:0] ahy, logic [31:0] bx, logic [31:0] by,
      logic [30:0] bhx, logic [30:0] bhy, logic [15:0] pnx, logic [15:0] pny,
      logic [31:0] poff);
    pair_t p;
    p.op = op; p.ax = ax; p.ay = ay; p.ahx = ahx; p.ahy = ahy;
    p.bx = bx; p.by = by; p.bhx = bhx; p.bhy = bhy;
    p.pnx = pnx; p.pny = pny; p.poff = poff;
    return p;
  endfunction

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || expected_contacts.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // directed: every pair type, zero lengths, edge ties, extremes, bad opcodes
    pending_pairs.push_back(make_pair(OP_CC, 0, 0, 100, 0, 0, 0, 50, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CC, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
    pending_pairs.push_back(make_pair(OP_CC, 32'h7FFF_FFFF, 0, 5, 0, 32'h8000_0000, 0,
                            5, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CC, 0, 0, 65536, 0, 3 << 16, 4 << 16, 65536, 0,
                            0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CB, 0, 0, 10, 0, 0, 0, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CB, 50, 0, 10, 0, 0, 0, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CB, -50, 0, 10, 0, 0, 0, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CB, 0, 50, 10, 0, 0, 0, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CB, 0, -50, 10, 0, 0, 0, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CB, 500, 300, 100, 0, 0, 0, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CB, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                            32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_CP, 0, 0, 100, 0, 0, 0, 0, 0, 16384, 0, 0));
    pending_pairs.push_back(make_pair(OP_CP, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF,
                            0, 0, 0, 0, 0, 16'h8000, 16'h7FFF, 32'h7FFF_FFFF));
    pending_pairs.push_back(make_pair(OP_CP, -3, 7, 1, 0, 0, 0, 0, 0, -16384, 0,
                            32'h8000_0000));
    pending_pairs.push_back(make_pair(OP_BB, 0, 0, 100, 100, 0, 0, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_BB, 0, 0, 100, 100, 150, 10, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_BB, 0, 0, 100, 100, -10, -150, 100, 100, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_BB, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF, 0, 0, 0));
    pending_pairs.push_back(make_pair(OP_BP, 0, 0, 100, 50, 0, 0, 0, 0, 0, 16384, 0));
    pending_pairs.push_back(make_pair(OP_BP, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF,
                            31'h7FFF_FFFF, 0, 0, 0, 0, 16'h8000, 16'h8000, 32'h8000_0000));
    pending_pairs.push_back(make_pair(OP_BP, 10, 10, 5, 5, 0, 0, 0, 0, 11585, -11585, 3));
    pending_pairs.push_back(make_pair(3'd5, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11));
    pending_pairs.push_back(make_pair(3'd7, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_drained();
    run_phase(200, 0, 0);
    run_phase(130, 87, 0);
    run_phase(130, 0, 87);
    // sender idles and receiver stalls at random, each with a 31 percent chance
    run_phase(110, 31, 31);
    run_phase(130, 0, 0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (80) @(posedge clk);
    if (error_count == 0 && expected_contacts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ narrowphase_collision_2d_unit.f @@
rtl/core/nc2d_pkg.sv
rtl/core/narrowphase_collision_2d_unit.sv
sim/tb_narrowphase_collision_2d_unit.sv
